// File: hdl/dmvd_pkg.sv
// Shared types, constants and helper functions for the dual magnetometer
// vehicle detector. No dependencies.
`timescale 1ns / 1ps

package dmvd_pkg;

    localparam int AXIS_BITS   = 16;
    localparam int COUNT_BITS  = 16;
    localparam int CFG_W       = 16;
    localparam int THR_W       = 32;
    localparam int TOTAL_W     = 32;
    localparam int PHASE_W     = 3;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;
    localparam int SQ_W        = 2 * AXIS_BITS;
    localparam int MAG_W       = SQ_W + 2;
    localparam int MCMP_W      = (MAG_W > THR_W) ? MAG_W : THR_W;
    localparam int CCMP_W      = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef logic [COUNT_BITS-1:0] count_t;

    typedef enum logic [4:0] {
        PH_WAIT  = 5'b00001,
        PH_RISE  = 5'b00010,
        PH_WIDTH = 5'b00100,
        PH_FALL  = 5'b01000,
        PH_QUIET = 5'b10000
    } phase_t;

    // Phase codes as reported on detector_phase
    localparam logic [PHASE_W-1:0] CODE_WAIT  = 3'd0;
    localparam logic [PHASE_W-1:0] CODE_RISE  = 3'd1;
    localparam logic [PHASE_W-1:0] CODE_WIDTH = 3'd2;
    localparam logic [PHASE_W-1:0] CODE_FALL  = 3'd3;
    localparam logic [PHASE_W-1:0] CODE_QUIET = 3'd4;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_THRESHOLD_SQ = 3'd0;
    localparam logic [2:0] REG_RISE_MIN     = 3'd1;
    localparam logic [2:0] REG_WIDTH_MIN    = 3'd2;
    localparam logic [2:0] REG_FALL_MIN     = 3'd3;
    localparam logic [2:0] REG_QUIET_MIN    = 3'd4;
    localparam logic [2:0] REG_OVERLAP_MIN  = 3'd5;
    localparam logic [2:0] REG_STUCK_LIMIT  = 3'd6;

    typedef struct packed {
        logic [THR_W-1:0] threshold_sq;
        logic [CFG_W-1:0] rise_min;
        logic [CFG_W-1:0] width_min;
        logic [CFG_W-1:0] fall_min;
        logic [CFG_W-1:0] quiet_min;
        logic [CFG_W-1:0] overlap_min;
        logic [CFG_W-1:0] stuck_limit;
    } cfg_t;

    // Classified sample handed from front end to back end
    typedef struct packed {
        logic sensor;
        logic high;
        logic low;
    } cls_t;

    function automatic logic [PHASE_W-1:0] phase_code(input phase_t p);
        logic [PHASE_W-1:0] c;
        begin
            case (p)
                PH_RISE:  c = CODE_RISE;
                PH_WIDTH: c = CODE_WIDTH;
                PH_FALL:  c = CODE_FALL;
                PH_QUIET: c = CODE_QUIET;
                default:  c = CODE_WAIT;
            endcase
            return c;
        end
    endfunction

    function automatic count_t sat_inc(input count_t c);
        begin
            return (c == '1) ? c : c + count_t'(1);
        end
    endfunction

    function automatic logic [CCMP_W-1:0] ext_cnt(input count_t c);
        begin
            return CCMP_W'(c);
        end
    endfunction

    function automatic logic [CCMP_W-1:0] ext_cfg(input logic [CFG_W-1:0] v);
        begin
            return CCMP_W'(v);
        end
    endfunction

endpackage

// File: hdl/dmvd_front.sv
// Front end: squares the three axes, sums and compares against the threshold.
// Two register stages with valid/ready flow. Depends on dmvd_pkg.
`timescale 1ns / 1ps

module dmvd_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  sensor_sel,
    input  logic signed [dmvd_pkg::AXIS_BITS-1:0] axis_x,
    input  logic signed [dmvd_pkg::AXIS_BITS-1:0] axis_y,
    input  logic signed [dmvd_pkg::AXIS_BITS-1:0] axis_z,
    input  logic [dmvd_pkg::THR_W-1:0]            threshold_sq,
    output logic                                  cls_valid,
    input  logic                                  cls_ready,
    output dmvd_pkg::cls_t                        cls
);
    import dmvd_pkg::*;

    logic              a_valid_reg;
    logic              a_sensor_reg;
    logic [SQ_W-1:0]   sx_reg, sy_reg, sz_reg;
    logic              b_valid_reg;
    cls_t              b_cls_reg;

    logic              a_ready, b_ready;
    logic signed [SQ_W-1:0] px, py, pz;
    logic [MAG_W-1:0]  mag;
    logic [MCMP_W-1:0] mag_c, thr_c;

    assign b_ready  = !b_valid_reg || cls_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb
    begin
        px = SQ_W'(axis_x) * SQ_W'(axis_x);
        py = SQ_W'(axis_y) * SQ_W'(axis_y);
        pz = SQ_W'(axis_z) * SQ_W'(axis_z);
    end

    // squares are never negative, so the product bits read as unsigned
    always_comb
    begin
        mag   = MAG_W'(sx_reg) + MAG_W'(sy_reg) + MAG_W'(sz_reg);
        mag_c = MCMP_W'(mag);
        thr_c = MCMP_W'(threshold_sq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_sensor_reg <= sensor_sel;
            sx_reg       <= px;
            sy_reg       <= py;
            sz_reg       <= pz;
        end
        if (b_ready && a_valid_reg)
        begin
            b_cls_reg.sensor <= a_sensor_reg;
            b_cls_reg.high   <= (mag_c > thr_c);
            b_cls_reg.low    <= (mag_c < thr_c);
        end
    end

    assign cls_valid = b_valid_reg;
    assign cls       = b_cls_reg;

endmodule

// File: hdl/dmvd_queue.sv
// Small FIFO of classified samples between front and back end.
// Depends on dmvd_pkg.
`timescale 1ns / 1ps

module dmvd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  dmvd_pkg::cls_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output dmvd_pkg::cls_t pop_data
);
    import dmvd_pkg::*;

    cls_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              push, pop;

    assign push_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + (QPTR_W+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: hdl/dmvd_back.sv
// Back end: per-sensor envelope state machines, counters, vehicle total and
// the output register. Depends on dmvd_pkg.
`timescale 1ns / 1ps

module dmvd_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dmvd_pkg::cfg_t                      cfg,
    input  logic                                cls_valid,
    output logic                                cls_ready,
    input  dmvd_pkg::cls_t                      cls,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                vehicle_seen,
    output logic [dmvd_pkg::TOTAL_W-1:0]        vehicle_total,
    output logic [dmvd_pkg::PHASE_W-1:0]        detector_phase,
    output logic                                stuck_warning
);
    import dmvd_pkg::*;

    phase_t             phase_reg [2];
    count_t             rise_reg  [2];
    count_t             width_reg [2];
    count_t             fall_reg  [2];
    count_t             quiet_reg [2];
    count_t             stuck_reg [2];
    logic [TOTAL_W-1:0] total_reg;

    logic               out_valid_reg;
    logic               seen_out_reg, warn_out_reg;
    logic [TOTAL_W-1:0] total_out_reg;
    logic [PHASE_W-1:0] phase_out_reg;

    logic               take, s;
    phase_t             ph, oph, np;
    count_t             rc, wc, fc, qc, owc, st;
    count_t             nrc, nwc, nfc, nqc;
    logic               seen, warn;
    logic [TOTAL_W-1:0] total_next;

    assign cls_ready = !out_valid_reg || out_ready;
    assign take      = cls_valid && cls_ready;

    always_comb
    begin
        s    = cls.sensor;
        ph   = s ? phase_reg[1] : phase_reg[0];
        oph  = s ? phase_reg[0] : phase_reg[1];
        rc   = s ? rise_reg[1]  : rise_reg[0];
        wc   = s ? width_reg[1] : width_reg[0];
        owc  = s ? width_reg[0] : width_reg[1];
        fc   = s ? fall_reg[1]  : fall_reg[0];
        qc   = s ? quiet_reg[1] : quiet_reg[0];
        st   = s ? stuck_reg[1] : stuck_reg[0];
        np   = ph;
        nrc  = rc;
        nwc  = wc;
        nfc  = fc;
        nqc  = qc;
        seen = 1'b0;
        warn = 1'b0;

        // stuck check sees the count left by this sensor's previous sample
        if (ext_cnt(st) > ext_cfg(cfg.stuck_limit))
        begin
            warn = 1'b1;
            st   = '0;
        end

        unique case (ph)
            PH_RISE:
            begin
                if (cls.high)
                begin
                    nrc = sat_inc(rc);
                    if (ext_cnt(rc) > ext_cfg(cfg.rise_min))
                    begin
                        nwc = count_t'(1);
                        np  = PH_WIDTH;
                    end
                end
                else
                    np = PH_WAIT;
            end
            PH_WIDTH:
            begin
                // a rise early in the other sensor's width is the same vehicle
                if (wc <= count_t'(1) && oph == PH_WIDTH &&
                    ext_cnt(owc) < ext_cfg(cfg.overlap_min))
                begin
                    nfc = count_t'(1);
                    np  = PH_FALL;
                end
                else if (cls.high)
                begin
                    nwc = sat_inc(wc);
                    if (ext_cnt(wc) > ext_cfg(cfg.width_min))
                    begin
                        nfc  = count_t'(1);
                        np   = PH_FALL;
                        seen = 1'b1;
                    end
                end
                else
                    np = PH_WAIT;
            end
            PH_FALL:
            begin
                if (cls.low)
                begin
                    nfc = sat_inc(fc);
                    if (ext_cnt(fc) > ext_cfg(cfg.fall_min))
                    begin
                        nqc = count_t'(1);
                        np  = PH_QUIET;
                    end
                end
                else
                    nfc = count_t'(1);
            end
            PH_QUIET:
            begin
                if (cls.low)
                begin
                    nqc = sat_inc(qc);
                    if (ext_cnt(qc) > ext_cfg(cfg.quiet_min))
                        np = PH_WAIT;
                end
                else
                    nqc = '0;
            end
            default:
            begin
                if (cls.high)
                begin
                    nrc = '0;
                    np  = PH_RISE;
                end
            end
        endcase

        if (np != ph)
            st = '0;
        if (ph inside {PH_RISE, PH_WIDTH, PH_FALL, PH_QUIET})
            st = sat_inc(st);
        else
            st = '0;

        total_next = total_reg + TOTAL_W'(seen);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                phase_reg[i] <= PH_WAIT;
                rise_reg[i]  <= '0;
                width_reg[i] <= '0;
                fall_reg[i]  <= '0;
                quiet_reg[i] <= '0;
                stuck_reg[i] <= '0;
            end
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg[s] <= np;
                rise_reg[s]  <= nrc;
                width_reg[s] <= nwc;
                fall_reg[s]  <= nfc;
                quiet_reg[s] <= nqc;
                stuck_reg[s] <= st;
                total_reg    <= total_next;
            end
            if (cls_ready)
                out_valid_reg <= cls_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            seen_out_reg  <= seen;
            warn_out_reg  <= warn;
            total_out_reg <= total_next;
            phase_out_reg <= phase_code(np);
        end
    end

    assign out_valid      = out_valid_reg;
    assign vehicle_seen   = seen_out_reg;
    assign vehicle_total  = total_out_reg;
    assign detector_phase = phase_out_reg;
    assign stuck_warning  = warn_out_reg;

endmodule

// File: hdl/dual_magnetometer_vehicle_detector.sv
// Top level of the dual magnetometer vehicle detector: APB register file,
// front end, queue and back end. Depends on dmvd_pkg, dmvd_front,
// dmvd_queue and dmvd_back.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready): one 3-axis sample per transfer,
//   tagged with sensor_sel (bit 0 picks sensor 0 or 1).
//   Output channel (out_valid/out_ready): exactly one result per sample,
//   in input order: vehicle_seen, vehicle_total, detector_phase,
//   stuck_warning.
//   Throughput: one sample per cycle, sustained while out_ready is high.
//   Path: each sample is registered in two front-end stages (the squares,
//   then the threshold compare), one queue slot and one output register;
//   the envelope update itself is done in the back end and registered
//   together with the result.
//   Stalls: when out_ready is low the output register holds its result;
//   the back end stops, the 4-entry queue fills, and then the front end
//   and finally in_ready drop. Each side restarts at full rate.
//   Reset (rst_n low, asynchronous): both sensors return to edge wait,
//   all counters and the vehicle total clear, registers take their
//   defaults, and all pipeline slots are emptied.
//   Configuration: APB, register i at byte address 4*i, writes only while
//   no sample is in flight. pready is tied high.
module dual_magnetometer_vehicle_detector (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // sample input
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  sensor_sel,
    input  logic signed [dmvd_pkg::AXIS_BITS-1:0] axis_x,
    input  logic signed [dmvd_pkg::AXIS_BITS-1:0] axis_y,
    input  logic signed [dmvd_pkg::AXIS_BITS-1:0] axis_z,
    // result output
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  vehicle_seen,
    output logic [dmvd_pkg::TOTAL_W-1:0]          vehicle_total,
    output logic [dmvd_pkg::PHASE_W-1:0]          detector_phase,
    output logic                                  stuck_warning,
    // APB configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [dmvd_pkg::ADDR_W-1:0]           paddr,
    input  logic [dmvd_pkg::DATA_W-1:0]           pwdata,
    output logic [dmvd_pkg::DATA_W-1:0]           prdata,
    output logic                                  pready
);
    import dmvd_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    cls_t       f_cls, q_cls;
    logic       f_valid, f_ready;
    logic       q_valid, q_ready;

    // ---------------- register file ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_sq <= THR_W'(1000000);
            cfg_reg.rise_min     <= CFG_W'(5);
            cfg_reg.width_min    <= CFG_W'(5);
            cfg_reg.fall_min     <= CFG_W'(5);
            cfg_reg.quiet_min    <= CFG_W'(5);
            cfg_reg.overlap_min  <= CFG_W'(3);
            cfg_reg.stuck_limit  <= CFG_W'(1000);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_THRESHOLD_SQ: cfg_reg.threshold_sq <= pwdata[THR_W-1:0];
                REG_RISE_MIN:     cfg_reg.rise_min     <= pwdata[CFG_W-1:0];
                REG_WIDTH_MIN:    cfg_reg.width_min    <= pwdata[CFG_W-1:0];
                REG_FALL_MIN:     cfg_reg.fall_min     <= pwdata[CFG_W-1:0];
                REG_QUIET_MIN:    cfg_reg.quiet_min    <= pwdata[CFG_W-1:0];
                REG_OVERLAP_MIN:  cfg_reg.overlap_min  <= pwdata[CFG_W-1:0];
                REG_STUCK_LIMIT:  cfg_reg.stuck_limit  <= pwdata[CFG_W-1:0];
                default:          ; // no register here
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_THRESHOLD_SQ: prdata = DATA_W'(cfg_reg.threshold_sq);
            REG_RISE_MIN:     prdata = DATA_W'(cfg_reg.rise_min);
            REG_WIDTH_MIN:    prdata = DATA_W'(cfg_reg.width_min);
            REG_FALL_MIN:     prdata = DATA_W'(cfg_reg.fall_min);
            REG_QUIET_MIN:    prdata = DATA_W'(cfg_reg.quiet_min);
            REG_OVERLAP_MIN:  prdata = DATA_W'(cfg_reg.overlap_min);
            REG_STUCK_LIMIT:  prdata = DATA_W'(cfg_reg.stuck_limit);
            default:          prdata = '0;
        endcase
    end

    // ---------------- front end: magnitude and threshold ----------------
    dmvd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sensor_sel   (sensor_sel),
        .axis_x       (axis_x),
        .axis_y       (axis_y),
        .axis_z       (axis_z),
        .threshold_sq (cfg_reg.threshold_sq),
        .cls_valid    (f_valid),
        .cls_ready    (f_ready),
        .cls          (f_cls)
    );

    // ---------------- decoupling queue ----------------
    dmvd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_cls),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_cls)
    );

    // ---------------- back end: envelope detectors ----------------
    dmvd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .cls_valid      (q_valid),
        .cls_ready      (q_ready),
        .cls            (q_cls),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .vehicle_seen   (vehicle_seen),
        .vehicle_total  (vehicle_total),
        .detector_phase (detector_phase),
        .stuck_warning  (stuck_warning)
    );

endmodule
